@@ hw/rtl/bimru_pkg.sv @@
`timescale 1ns / 1ps
package bimru_pkg;

   localparam int unsigned SETS = 1024;
   localparam int unsigned WAYS = 16;

   localparam int unsigned SET_W = 10;
   localparam int unsigned WAY_W = 4;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned THR_W = 17;
   localparam int unsigned RND_W = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CLR_W = $clog2(SETS) + 1;
   localparam int unsigned RAM_ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;

   localparam logic [RND_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [RND_W-1:0] LFSR_TOGGLE = 16'hB400;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'h10000;

   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD_ADDR = 3'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_VICTIM = 2'd0,
      CMD_HIT = 2'd1,
      CMD_FILL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

@@ hw/rtl/bimru_if.sv @@
`timescale 1ns / 1ps
interface bimru_req_if;
   logic valid;
   logic ready;
   logic [bimru_pkg::CMD_W-1:0] command;
   logic [bimru_pkg::SET_W-1:0] set_index;
   logic [bimru_pkg::WAY_W-1:0] way_id;

   modport source (output valid, command, set_index, way_id, input ready);
   modport sink (input valid, command, set_index, way_id, output ready);
endinterface

interface bimru_rsp_if;
   logic valid;
   logic ready;
   logic [bimru_pkg::WAY_W-1:0] victim_way;
   logic bits_cleared;
   logic inserted_as_mru;

   modport source (output valid, victim_way, bits_cleared, inserted_as_mru, input ready);
   modport sink (input valid, victim_way, bits_cleared, inserted_as_mru, output ready);
endinterface

@@ hw/rtl/bimru_ram.sv @@
`timescale 1ns / 1ps
module bimru_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bimru_lfsr.sv @@
`timescale 1ns / 1ps
module bimru_lfsr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   output logic [bimru_pkg::RND_W-1:0] value
);
   import bimru_pkg::*;

   logic [RND_W-1:0] shift_ff;
   logic [RND_W-1:0] shift_in;

   // galois form, right shift, toggle taps when the low bit falls out
   always_comb begin
      shift_in = shift_ff;
      if (step) begin
         shift_in = {1'b0, shift_ff[RND_W-1:1]} ^ (shift_ff[0] ? LFSR_TOGGLE : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= LFSR_SEED;
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign value = shift_ff;

endmodule

@@ hw/rtl/bimodal_insertion_mru_bit_replacement_unit.sv @@
`timescale 1ns / 1ps
// Bimodal-insertion NRU replacement unit: one MRU bit per way for each of the
// SETS sets, held in a synchronous single-write, single-read memory. Every
// word (find victim, hit update, fill update) is a read of the set's MRU word
// followed by the write-back and the result once the output register is free,
// so the unit takes no new request word until the last one is through. A
// finished result sits in an output register, so the next request is taken
// while the result still waits. After reset the unit sweeps the memory to
// zero, one set per cycle, and accepts no request until the sweep is done;
// the threshold register can be written during the sweep. A fill inserts as
// MRU when the 16-bit LFSR value is below insert_mru_threshold (byte
// address 0); reset value 65536 means always.
module bimodal_insertion_mru_bit_replacement_unit (
   input  logic                              clock,
   input  logic                              reset,
   bimru_req_if.sink                         req_chan,
   bimru_rsp_if.source                       rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bimru_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bimru_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bimru_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);
   import bimru_pkg::*;

   state_type state_ff, state_in;

   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [THR_W-1:0] threshold_ff, threshold_in;

   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [WAY_W-1:0] way_ff, way_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WAY_W-1:0] victim_ff, victim_in;
   logic             cleared_ff, cleared_in;
   logic             inserted_ff, inserted_in;

   logic                  ram_we, ram_re;
   logic [RAM_ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WAYS-1:0]       ram_wdata, ram_rdata;

   logic             req_ready;
   logic             req_fire;
   logic             rsp_free;
   logic             load_rsp;
   logic             clear_we;
   logic             clr_done;

   logic             set_ok, way_ok, all_set, draw_mru;
   logic             upd_we, lfsr_step;
   logic [WAY_W-1:0] victim_c;
   logic [WAYS-1:0]  way_bit, new_word;
   logic [RND_W-1:0] rnd;

   bimru_ram #(
      .DEPTH  (SETS),
      .WIDTH  (WAYS),
      .ADDR_W (RAM_ADDR_W)
   ) u_mru_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bimru_lfsr u_lfsr (
      .clock (clock),
      .reset (reset),
      .step  (lfsr_step),
      .value (rnd)
   );

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr == REG_THRESHOLD_ADDR) ? CSR_DATA_W'(threshold_ff) : '0;

   always_comb begin
      threshold_in = threshold_ff;
      if (psel && penable && pwrite && paddr == REG_THRESHOLD_ADDR) begin
         threshold_in = pwdata[THR_W-1:0];
      end
   end

   // lookup on the word read back from the memory
   assign set_ok = 32'(set_ff) < SETS;
   assign way_ok = 32'(way_ff) < WAYS;
   assign all_set = &ram_rdata;
   assign draw_mru = {1'b0, rnd} < threshold_ff;
   assign way_bit = WAYS'(1) << way_ff;

   always_comb begin
      victim_c = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!ram_rdata[w]) begin
            victim_c = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_word = ram_rdata;
      upd_we = 1'b0;
      victim_in = '0;
      cleared_in = 1'b0;
      inserted_in = 1'b0;
      lfsr_step = 1'b0;
      unique case (cmd_ff)
         CMD_VICTIM: begin
            if (set_ok) begin
               if (all_set) begin
                  new_word = '0;
                  upd_we = load_rsp;
                  cleared_in = 1'b1;
               end else begin
                  victim_in = victim_c;
               end
            end
         end
         CMD_HIT: begin
            if (set_ok && way_ok) begin
               new_word = ram_rdata | way_bit;
               upd_we = load_rsp;
            end
         end
         CMD_FILL: begin
            if (set_ok && way_ok) begin
               new_word = draw_mru ? (ram_rdata | way_bit) : (ram_rdata & ~way_bit);
               upd_we = load_rsp;
               inserted_in = draw_mru;
               lfsr_step = load_rsp;
            end
         end
         default: begin
            // unused command leaves everything alone
         end
      endcase
   end

   // control
   assign req_fire = req_chan.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign clr_done = clr_cnt_ff == CLR_W'(SETS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      clear_we = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clear_we = 1'b1;
         ST_IDLE: req_ready = 1'b1;
         ST_LOOKUP: load_rsp = rsp_free;
         default: begin
         end
      endcase
   end

   assign ram_re = req_fire;
   assign ram_raddr = RAM_ADDR_W'(req_chan.set_index);
   assign ram_we = clear_we || upd_we;
   assign ram_waddr = clear_we ? clr_cnt_ff[RAM_ADDR_W-1:0] : RAM_ADDR_W'(set_ff);
   assign ram_wdata = clear_we ? '0 : new_word;

   assign clr_cnt_in = clear_we ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;
   assign cmd_in = req_fire ? req_chan.command : cmd_ff;
   assign set_in = req_fire ? req_chan.set_index : set_ff;
   assign way_in = req_fire ? req_chan.way_id : way_ff;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      set_ff <= set_in;
      way_ff <= way_in;
      if (load_rsp) begin
         victim_ff <= victim_in;
         cleared_ff <= cleared_in;
         inserted_ff <= inserted_in;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.victim_way = victim_ff;
   assign rsp_chan.bits_cleared = cleared_ff;
   assign rsp_chan.inserted_as_mru = inserted_ff;

   // no word is taken while the sweep is still running
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during memory sweep");

   // update writes only come with a result being loaded
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      upd_we |-> load_rsp && state_ff == ST_LOOKUP)
      else $error("mru write-back without result");

   // the random source only moves on a fill
   a_lfsr_only_on_fill: assert property (@(posedge clock) disable iff (reset)
      lfsr_step |-> cmd_ff == CMD_FILL && load_rsp)
      else $error("lfsr stepped outside a fill");

   // a blocked output keeps the lookup waiting
   a_lookup_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP && rsp_valid_ff && !rsp_chan.ready |=> state_ff == ST_LOOKUP)
      else $error("lookup left while output blocked");

   // a word accepted leads to a lookup in the next cycle
   a_accept_then_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOOKUP)
      else $error("accepted word did not enter lookup");

endmodule
